>>> rtl/core/bdq_pkg.sv
// Shared types, codes and defaults of the bounded double-ended queue.
package bdq_pkg;

	localparam int DEPTH_DEFAULT      = 16;
	localparam int DATA_WIDTH_DEFAULT = 32;

	localparam int OPCODE_W   = 2;
	localparam int VALUE_W    = 32;
	localparam int STATUS_W   = 2;
	localparam int FILL_W     = 5;
	localparam int CAPACITY_W = 5;

	localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = 5'd16;

	localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 2'd3;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [VALUE_W-1:0]  push_value;
	} req_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0]  pop_value;
		logic [STATUS_W-1:0] status;
		logic [FILL_W-1:0]   fill_count;
	} rsp_item_t;

	// Operation strobes broadcast to every cell of the chain.
	typedef struct packed {
		logic push_front;
		logic push_back;
		logic pop_front;
		logic pop_back;
	} cell_cmd_t;

endpackage

>>> rtl/core/bdq_cell.sv
// One storage cell of the queue chain, with its slot of the back-pop return path.
module bdq_cell #(
	parameter int IDX = 0,
	parameter int DW  = 32,
	parameter int CW  = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bdq_pkg::cell_cmd_t cmd,
	input  logic [CW-1:0]      count,
	input  logic [DW-1:0]      word,
	input  logic [DW-1:0]      left_data,
	input  logic [DW-1:0]      right_data,
	input  logic               right_carry_vld,
	input  logic [DW-1:0]      right_carry_data,
	output logic [DW-1:0]      data,
	output logic               carry_vld,
	output logic [DW-1:0]      carry_data
);
	import bdq_pkg::*;

	localparam logic [CW-1:0] MY_IDX   = CW'(IDX);
	localparam logic [CW-1:0] NEXT_IDX = CW'(IDX + 1);

	logic [DW-1:0] data_q;
	logic          carry_vld_q;
	logic [DW-1:0] carry_data_q;
	logic          is_tail_slot;
	logic          is_last_entry;
	logic          take_carry;

	// The first free slot takes a back push; the last held entry leaves on a back pop.
	assign is_tail_slot  = (count == MY_IDX);
	assign is_last_entry = (count == NEXT_IDX);
	assign take_carry    = cmd.pop_back && is_last_entry;

	always_ff @(posedge clk) begin
		if (cmd.push_front) begin
			data_q <= left_data;
		end else if (cmd.pop_front) begin
			data_q <= right_data;
		end else if (cmd.push_back && is_tail_slot) begin
			data_q <= word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_vld_q <= 1'b0;
		end else begin
			carry_vld_q <= take_carry || right_carry_vld;
		end
	end

	always_ff @(posedge clk) begin
		carry_data_q <= take_carry ? data_q : right_carry_data;
	end

	assign data       = data_q;
	assign carry_vld  = carry_vld_q;
	assign carry_data = carry_data_q;

endmodule

>>> rtl/core/bounded_double_ended_queue_unit.sv
// Top level of the bounded double-ended queue: control, result register and the cell chain.
//
// The queue holds up to DEPTH words in a chain of cells kept packed toward
// cell 0, which always holds the front entry; a fill count says how many
// cells are in use, and a capacity register (reset 16, saturated at DEPTH)
// caps how many pushes are allowed. Push front shifts the whole chain one
// cell toward the back, pop front shifts it one cell toward the front, and
// push back writes the first free cell, each in the cycle the item is
// accepted, so the result is registered together with the chain update, and
// another item can be accepted in the very next cycle once the receiver
// takes the result. A pop at the back lifts the last entry into a return
// chain that moves one cell toward cell 0 per cycle; no item is accepted
// until its result is registered. Refused operations report full or empty,
// leave the queue unchanged and return a zero word. Capacity is written
// through cfg_we and cfg_data by the user, only while the block is idle;
// the block does not enforce this. No clearing pass is needed after reset.
module bounded_double_ended_queue_unit #(
	parameter int DEPTH      = bdq_pkg::DEPTH_DEFAULT,
	parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_ready,
	input  bdq_pkg::req_item_t                   req,
	output logic                                 rsp_valid,
	input  logic                                 rsp_ready,
	output bdq_pkg::rsp_item_t                   rsp,
	input  logic                                 cfg_we,
	input  logic [bdq_pkg::CAPACITY_W-1:0]       cfg_data
);
	import bdq_pkg::*;

	// Fill count width and a common width for comparing it with the capacity.
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > CAPACITY_W) ? CW : CAPACITY_W;
	localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

	logic [CAPACITY_W-1:0] capacity_q;
	logic [CW-1:0]         count_q;
	logic                  busy_q;
	logic                  rsp_valid_q;
	rsp_item_t             rsp_q;

	logic                  accept;
	logic                  full;
	logic                  empty;
	logic [LW-1:0]         cap_l;
	logic [LW-1:0]         limit_l;
	logic [STATUS_W-1:0]   status;
	logic                  is_push;
	logic                  is_pop;
	logic                  op_ok;
	logic                  defer;
	logic [CW-1:0]         count_next;
	logic [LW-1:0]         count_next_l;
	logic [DATA_WIDTH-1:0] word;
	logic [DATA_WIDTH+VALUE_W-1:0] word_ext;
	logic [DATA_WIDTH+VALUE_W-1:0] front_ext;
	logic [DATA_WIDTH+VALUE_W-1:0] carry_ext;
	cell_cmd_t             cmd;

	logic [DATA_WIDTH-1:0] cell_data       [DEPTH];
	logic                  cell_carry_vld  [DEPTH];
	logic [DATA_WIDTH-1:0] cell_carry_data [DEPTH];

	// A new item is taken only when no back pop is in flight and the result
	// register is free or being emptied in this cycle.
	assign req_ready = !busy_q && (!rsp_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;

	// Only the low DATA_WIDTH bits of a pushed word are kept.
	assign word_ext = {{DATA_WIDTH{1'b0}}, req.push_value};
	assign word     = word_ext[DATA_WIDTH-1:0];

	// A capacity above the chain length saturates at DEPTH.
	assign cap_l   = LW'(capacity_q);
	assign limit_l = (cap_l > DEPTH_L) ? DEPTH_L : cap_l;
	assign full    = (LW'(count_q) >= limit_l);
	assign empty   = (count_q == '0);

	always_comb begin
		status  = ST_DONE;
		is_push = 1'b0;
		is_pop  = 1'b0;
		case (req.opcode)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				is_push = 1'b1;
				if (full) begin
					status = ST_FULL;
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				is_pop = 1'b1;
				if (empty) begin
					status = ST_EMPTY;
				end
			end
			default: begin
				status = ST_DONE;
			end
		endcase
	end

	assign op_ok = accept && (status == ST_DONE);
	assign defer = op_ok && (req.opcode == OP_POP_BACK);

	assign cmd.push_front = op_ok && (req.opcode == OP_PUSH_FRONT);
	assign cmd.push_back  = op_ok && (req.opcode == OP_PUSH_BACK);
	assign cmd.pop_front  = op_ok && (req.opcode == OP_POP_FRONT);
	assign cmd.pop_back   = defer;

	always_comb begin
		count_next = count_q;
		if (op_ok && is_push) begin
			count_next = count_q + CW'(1);
		end else if (op_ok && is_pop) begin
			count_next = count_q - CW'(1);
		end
	end

	assign count_next_l = LW'(count_next);

	// Words leave the chain at cell 0, both for a front pop and on the return path.
	assign front_ext = {{VALUE_W{1'b0}}, cell_data[0]};
	assign carry_ext = {{VALUE_W{1'b0}}, cell_carry_data[0]};

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic [DATA_WIDTH-1:0] left_data;
			logic [DATA_WIDTH-1:0] right_data;
			logic                  right_carry_vld;
			logic [DATA_WIDTH-1:0] right_carry_data;

			if (gi == 0) begin : g_head
				assign left_data = word;
			end else begin : g_body
				assign left_data = cell_data[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_tail
				assign right_data       = '0;
				assign right_carry_vld  = 1'b0;
				assign right_carry_data = '0;
			end else begin : g_inner
				assign right_data       = cell_data[gi+1];
				assign right_carry_vld  = cell_carry_vld[gi+1];
				assign right_carry_data = cell_carry_data[gi+1];
			end

			bdq_cell #(
				.IDX (gi),
				.DW  (DATA_WIDTH),
				.CW  (CW)
			) u_cell (
				.clk              (clk),
				.arst_n           (arst_n),
				.cmd              (cmd),
				.count            (count_q),
				.word             (word),
				.left_data        (left_data),
				.right_data       (right_data),
				.right_carry_vld  (right_carry_vld),
				.right_carry_data (right_carry_data),
				.data             (cell_data[gi]),
				.carry_vld        (cell_carry_vld[gi]),
				.carry_data       (cell_carry_data[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	// Result handshake and the wait for a back pop's word to reach cell 0.
	// A returning word and a new item never meet, since nothing is accepted
	// while a back pop is in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			busy_q      <= 1'b0;
		end else begin
			if (busy_q && cell_carry_vld[0]) begin
				rsp_valid_q <= 1'b1;
				busy_q      <= 1'b0;
			end else if (accept && !defer) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (defer) begin
				busy_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.status     <= status;
			rsp_q.fill_count <= count_next_l[FILL_W-1:0];
			rsp_q.pop_value  <= cmd.pop_front ? front_ext[VALUE_W-1:0] : '0;
		end else if (busy_q && cell_carry_vld[0]) begin
			rsp_q.pop_value <= carry_ext[VALUE_W-1:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The fill count never runs past the chain length.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count exceeds chain length");

	// A word on the return path reaches cell 0 only while a back pop waits for it.
	a_carry_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cell_carry_vld[0] |-> busy_q)
		else $error("return word arrived with no back pop pending");

	// No new item is taken while a back pop is in flight.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req_ready)
		else $error("item accepted during a back pop");

	// A successful push grows the fill count by exactly one.
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(op_ok && is_push) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("push did not grow the fill count");

	// A back pop's result is registered in the cycle its word reaches cell 0.
	a_carry_result: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cell_carry_vld[0]) |=> (rsp_valid_q && !busy_q))
		else $error("back pop result was not registered");

endmodule

>>> tb/sv/bounded_double_ended_queue_unit_tb.sv
// Self-checking testbench for the bounded double-ended queue: directed cases, then random traffic.
module bounded_double_ended_queue_unit_tb;
	import bdq_pkg::*;

	localparam int RING_DEPTH = DEPTH_DEFAULT;
	localparam int POS_W      = $clog2(RING_DEPTH);

	// Every input of the block starts at a known value; reset is held low
	// from time zero.
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	req_item_t             req       = '0;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	rsp_item_t             rsp;
	logic                  cfg_we    = 1'b0;
	logic [CAPACITY_W-1:0] cfg_data  = '0;

	// Shadow copy of the queue. It is advanced once for every item the
	// block accepts, and each step leaves one expected result behind.
	logic [VALUE_W-1:0]    ring_words [RING_DEPTH];
	logic [POS_W-1:0]      head_pos   = '0;
	logic [FILL_W-1:0]     held       = '0;
	logic [CAPACITY_W-1:0] cap_reg    = CAPACITY_RESET;

	// Results still owed by the block, oldest first.
	rsp_item_t pending_results [$];

	int errors         = 0;
	int send_idle_pct  = 0;
	int recv_idle_pct  = 0;

	bounded_double_ended_queue_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs on a handshake.
	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Works out the result of one accepted operation and updates the shadow
	// queue. The limit on entries is the capacity, saturated at the ring
	// depth. A refused operation leaves the queue alone and returns a zero
	// word; every push returns a zero word as well.
	function automatic rsp_item_t apply_op(req_item_t item);
		rsp_item_t         res;
		logic [FILL_W-1:0] lim;
		logic [POS_W-1:0]  slot;

		res        = '0;
		res.status = ST_DONE;
		lim = (cap_reg > CAPACITY_W'(RING_DEPTH)) ? FILL_W'(RING_DEPTH) : FILL_W'(cap_reg);
		case (item.opcode)
		OP_PUSH_FRONT, OP_PUSH_BACK: begin
			if (held >= lim) begin
				res.status = ST_FULL;
			end else if (item.opcode == OP_PUSH_FRONT) begin
				head_pos = head_pos - 1'b1;
				ring_words[head_pos] = item.push_value;
				held = held + 1'b1;
			end else begin
				// A push is only taken below the depth, so the low bits of
				// the count give the first free slot past the front.
				slot = head_pos + held[POS_W-1:0];
				ring_words[slot] = item.push_value;
				held = held + 1'b1;
			end
		end
		default: begin
			if (held == '0) begin
				res.status = ST_EMPTY;
			end else if (item.opcode == OP_POP_FRONT) begin
				res.pop_value = ring_words[head_pos];
				head_pos = head_pos + 1'b1;
				held = held - 1'b1;
			end else begin
				// With a full ring the low count bits are zero, and the
				// wrap of the subtraction still lands on the last entry.
				slot = head_pos + held[POS_W-1:0] - 1'b1;
				res.pop_value = ring_words[slot];
				held = held - 1'b1;
			end
		end
		endcase
		res.fill_count = held;
		return res;
	endfunction

	// The receiver stalls at random, per cycle, at the current idle rate.
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Every result taken by the receiver is matched against the oldest
	// expectation. Signals are sampled right after the edge, so they hold
	// the values that the edge itself saw.
	initial begin
		rsp_item_t want;

		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && rsp_ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result pop_value=%h status=%0d fill_count=%0d",
						$time, rsp.pop_value, rsp.status, rsp.fill_count);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (rsp.pop_value !== want.pop_value) begin
						$display("%0t: pop_value expected %h actual %h",
							$time, want.pop_value, rsp.pop_value);
						errors++;
					end
					if (rsp.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, rsp.status);
						errors++;
					end
					if (rsp.fill_count !== want.fill_count) begin
						$display("%0t: fill_count expected %0d actual %0d",
							$time, want.fill_count, rsp.fill_count);
						errors++;
					end
				end
			end
		end
	end

	// Offers one item and returns in the time step of the edge that took it.
	// Valid stays high on return, so the caller either sends again or drops
	// valid before time moves on; that way valid is never lowered and raised
	// in the same step.
	task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] value);
		req_item_t item;

		item.opcode     = op;
		item.push_value = value;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do begin
			@(posedge clk);
		end while (!req_ready);
		pending_results.push_back(apply_op(item));
	endtask

	task automatic idle_sender();
		req_valid <= 1'b0;
	endtask

	// The capacity changes only once every owed result is in. The queue
	// contents are kept, so a lower limit can fall below the fill.
	task automatic write_capacity(input logic [CAPACITY_W-1:0] value);
		idle_sender();
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we  <= 1'b0;
		cap_reg  = value;
	endtask

	// Pops from both ends of the empty queue right after reset.
	task automatic test_empty_pops();
		send_item(OP_POP_FRONT, 32'hFFFF_FFFF);
		send_item(OP_POP_BACK, 32'h0000_0000);
	endtask

	// Mixes pushes and pops at both ends with extreme words, so each end
	// must return exactly the entry that went in last on that side, then
	// runs one pop past the last entry.
	task automatic test_end_order();
		send_item(OP_PUSH_FRONT, 32'hFFFF_FFFF);
		send_item(OP_PUSH_BACK, 32'h0000_0000);
		send_item(OP_PUSH_FRONT, 32'hA5A5_A5A5);
		send_item(OP_PUSH_BACK, 32'h5A5A_5A5A);
		send_item(OP_POP_BACK, 32'h0000_0000);
		send_item(OP_POP_FRONT, 32'hFFFF_FFFF);
		send_item(OP_POP_BACK, 32'h1234_5678);
		send_item(OP_POP_FRONT, 32'h0000_0000);
		send_item(OP_POP_FRONT, 32'h0000_0000);
	endtask

	// A zero capacity refuses every push. A small capacity refuses the push
	// that would exceed it. Lowering the limit under the current fill keeps
	// the entries, and pushes stay refused until pops bring the count below
	// the new limit.
	task automatic test_capacity_limits();
		write_capacity(5'd0);
		send_item(OP_PUSH_FRONT, 32'h0000_0001);
		send_item(OP_PUSH_BACK, 32'h8000_0000);
		write_capacity(5'd2);
		send_item(OP_PUSH_BACK, 32'h1111_1111);
		send_item(OP_PUSH_FRONT, 32'h2222_2222);
		send_item(OP_PUSH_BACK, 32'h3333_3333);
		write_capacity(5'd1);
		send_item(OP_PUSH_FRONT, 32'h4444_4444);
		send_item(OP_POP_FRONT, 32'h0000_0000);
		send_item(OP_PUSH_BACK, 32'h5555_5555);
		send_item(OP_POP_BACK, 32'h0000_0000);
		send_item(OP_PUSH_BACK, 32'hDEAD_BEEF);
	endtask

	// Random traffic under one capacity. It runs in bursts that lean toward
	// pushes, toward pops or toward neither, so the queue swings between
	// empty and its limit and both refusals come up often.
	task automatic test_random_traffic(input logic [CAPACITY_W-1:0] cap, input int count);
		int                  sent;
		int                  burst;
		int                  push_pct;
		logic [OPCODE_W-1:0] op;
		logic [VALUE_W-1:0]  value;

		write_capacity(cap);
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(8, 40);
			case ($urandom_range(2))
			0: push_pct = 80;
			1: push_pct = 20;
			default: push_pct = 50;
			endcase
			repeat (burst) begin
				if ($urandom_range(99) < push_pct) begin
					op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
				end else begin
					op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
				end
				case ($urandom_range(15))
				0: value = '0;
				1: value = '1;
				default: value = $urandom;
				endcase
				send_item(op, value);
				sent++;
			end
		end
	endtask

	initial begin
		int drain;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed cases run with the sender idling 24 percent of the cycles
		// and the receiver 45 percent.
		send_idle_pct = 24;
		recv_idle_pct = 45;
		test_empty_pops();
		test_end_order();
		test_capacity_limits();

		// A capacity above the depth must saturate at the depth.
		test_random_traffic(5'd31, 250);
		test_random_traffic(5'd16, 200);
		test_random_traffic(5'd3, 120);

		send_idle_pct = 45;
		recv_idle_pct = 24;
		test_random_traffic(5'd17, 250);
		test_random_traffic(5'd0, 60);
		test_random_traffic(5'd9, 250);

		// Back-to-back items with the receiver always ready.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(5'd16, 250);
		test_random_traffic(5'd1, 100);
		test_random_traffic(5'd12, 220);

		// Wait for the owed results, then long enough for a full-depth pop
		// at the back to surface any stray result.
		idle_sender();
		drain = 0;
		while (pending_results.size() != 0 && drain < 5000) begin
			@(posedge clk);
			drain++;
		end
		repeat (40) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, pending_results.size());
			errors++;
		end

		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/bdq_pkg.sv
rtl/core/bdq_cell.sv
rtl/core/bounded_double_ended_queue_unit.sv
tb/sv/bounded_double_ended_queue_unit_tb.sv
